@@ rtl/scan_code_to_char_decoder_assert.svh @@
// assertion macros for the scan code decoder
// needs clk_i and rst_ni in the scope of use
`ifndef SCAN_CODE_TO_CHAR_DECODER_ASSERT_SVH
`define SCAN_CODE_TO_CHAR_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scd assertion failed");

// next-cycle implication, checked outside reset
`define SCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scd assertion failed");

`endif

@@ rtl/scd_pkg.sv @@
// shared types, constants and key maps for the scan code decoder
// no dependencies
package scd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] mod_t;

  // modifier bit positions
  localparam int unsigned ModShift  = 0;
  localparam int unsigned ModCtl    = 1;
  localparam int unsigned ModAlt    = 2;
  localparam int unsigned ModCaps   = 3;
  localparam int unsigned ModNum    = 4;
  localparam int unsigned ModScroll = 5;
  localparam int unsigned ModE0     = 6;

  // scan codes with a role of their own
  localparam byte_t CodePrefix  = 8'hE0;
  localparam byte_t CodeLCtl    = 8'h1D;
  localparam byte_t CodeLShift  = 8'h2A;
  localparam byte_t CodeRShift  = 8'h36;
  localparam byte_t CodeLAlt    = 8'h38;
  localparam byte_t CodeRCtl    = 8'h9D;
  localparam byte_t CodeRAlt    = 8'hB8;
  localparam byte_t CodeCaps    = 8'h3A;
  localparam byte_t CodeNum     = 8'h45;
  localparam byte_t CodeScroll  = 8'h46;

  // special key codes on the output
  localparam byte_t KeyHome = 8'hE0;
  localparam byte_t KeyEnd  = 8'hE1;
  localparam byte_t KeyUp   = 8'hE2;
  localparam byte_t KeyDown = 8'hE3;
  localparam byte_t KeyLeft = 8'hE4;
  localparam byte_t KeyRt   = 8'hE5;
  localparam byte_t KeyPgUp = 8'hE6;
  localparam byte_t KeyPgDn = 8'hE7;
  localparam byte_t KeyIns  = 8'hE8;
  localparam byte_t KeyDel  = 8'hE9;

  // hold modifiers named by a code
  function automatic mod_t hold_bits(input byte_t idx);
    mod_t m;
    m = '0;
    unique case (idx)
      CodeLCtl, CodeRCtl:     m[ModCtl]   = 1'b1;
      CodeLShift, CodeRShift: m[ModShift] = 1'b1;
      CodeLAlt, CodeRAlt:     m[ModAlt]   = 1'b1;
      default:                m = '0;
    endcase
    return m;
  endfunction

  // lock modifiers toggled by a code
  function automatic mod_t lock_bits(input byte_t idx);
    mod_t m;
    m = '0;
    unique case (idx)
      CodeCaps:   m[ModCaps]   = 1'b1;
      CodeNum:    m[ModNum]    = 1'b1;
      CodeScroll: m[ModScroll] = 1'b1;
      default:    m = '0;
    endcase
    return m;
  endfunction

  // navigation keys, reached through the prefix
  function automatic byte_t nav_map(input byte_t idx);
    byte_t c;
    unique case (idx)
      8'hC7:   c = KeyHome;
      8'hC8:   c = KeyUp;
      8'hC9:   c = KeyPgUp;
      8'hCB:   c = KeyLeft;
      8'hCD:   c = KeyRt;
      8'hCF:   c = KeyEnd;
      8'hD0:   c = KeyDown;
      8'hD1:   c = KeyPgDn;
      8'hD2:   c = KeyIns;
      8'hD3:   c = KeyDel;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // entries that plain and shifted maps share
  function automatic byte_t common_map(input byte_t idx);
    byte_t c;
    unique case (idx)
      8'h01:   c = 8'h1B;
      8'h0E:   c = 8'h08;
      8'h0F:   c = 8'h09;
      8'h1C:   c = 8'h0A;
      8'h37:   c = 8'h2A;
      8'h39:   c = 8'h20;
      8'h47:   c = 8'h37;
      8'h48:   c = 8'h38;
      8'h49:   c = 8'h39;
      8'h4A:   c = 8'h2D;
      8'h4B:   c = 8'h34;
      8'h4C:   c = 8'h35;
      8'h4D:   c = 8'h36;
      8'h4E:   c = 8'h2B;
      8'h4F:   c = 8'h31;
      8'h50:   c = 8'h32;
      8'h51:   c = 8'h33;
      8'h52:   c = 8'h30;
      8'h53:   c = 8'h2E;
      8'h9C:   c = 8'h0A;
      8'hB5:   c = 8'h2F;
      default: c = nav_map(idx);
    endcase
    return c;
  endfunction

  // unshifted map
  function automatic byte_t plain_map(input byte_t idx);
    byte_t c;
    unique case (idx)
      8'h02: c = 8'h31;  8'h03: c = 8'h32;  8'h04: c = 8'h33;  8'h05: c = 8'h34;
      8'h06: c = 8'h35;  8'h07: c = 8'h36;  8'h08: c = 8'h37;  8'h09: c = 8'h38;
      8'h0A: c = 8'h39;  8'h0B: c = 8'h30;  8'h0C: c = 8'h2D;  8'h0D: c = 8'h3D;
      8'h10: c = 8'h71;  8'h11: c = 8'h77;  8'h12: c = 8'h65;  8'h13: c = 8'h72;
      8'h14: c = 8'h74;  8'h15: c = 8'h79;  8'h16: c = 8'h75;  8'h17: c = 8'h69;
      8'h18: c = 8'h6F;  8'h19: c = 8'h70;  8'h1A: c = 8'h5B;  8'h1B: c = 8'h5D;
      8'h1E: c = 8'h61;  8'h1F: c = 8'h73;  8'h20: c = 8'h64;  8'h21: c = 8'h66;
      8'h22: c = 8'h67;  8'h23: c = 8'h68;  8'h24: c = 8'h6A;  8'h25: c = 8'h6B;
      8'h26: c = 8'h6C;  8'h27: c = 8'h3B;  8'h28: c = 8'h27;  8'h29: c = 8'h60;
      8'h2B: c = 8'h5C;  8'h2C: c = 8'h7A;  8'h2D: c = 8'h78;  8'h2E: c = 8'h63;
      8'h2F: c = 8'h76;  8'h30: c = 8'h62;  8'h31: c = 8'h6E;  8'h32: c = 8'h6D;
      8'h33: c = 8'h2C;  8'h34: c = 8'h2E;  8'h35: c = 8'h2F;
      default: c = common_map(idx);
    endcase
    return c;
  endfunction

  // shifted map
  function automatic byte_t upper_map(input byte_t idx);
    byte_t c;
    unique case (idx)
      8'h02: c = 8'h21;  8'h03: c = 8'h40;  8'h04: c = 8'h23;  8'h05: c = 8'h24;
      8'h06: c = 8'h25;  8'h07: c = 8'h5E;  8'h08: c = 8'h26;  8'h09: c = 8'h2A;
      8'h0A: c = 8'h28;  8'h0B: c = 8'h29;  8'h0C: c = 8'h5F;  8'h0D: c = 8'h2B;
      8'h10: c = 8'h51;  8'h11: c = 8'h57;  8'h12: c = 8'h45;  8'h13: c = 8'h52;
      8'h14: c = 8'h54;  8'h15: c = 8'h59;  8'h16: c = 8'h55;  8'h17: c = 8'h49;
      8'h18: c = 8'h4F;  8'h19: c = 8'h50;  8'h1A: c = 8'h7B;  8'h1B: c = 8'h7D;
      8'h1E: c = 8'h41;  8'h1F: c = 8'h53;  8'h20: c = 8'h44;  8'h21: c = 8'h46;
      8'h22: c = 8'h47;  8'h23: c = 8'h48;  8'h24: c = 8'h4A;  8'h25: c = 8'h4B;
      8'h26: c = 8'h4C;  8'h27: c = 8'h3A;  8'h28: c = 8'h22;  8'h29: c = 8'h7E;
      8'h2B: c = 8'h7C;  8'h2C: c = 8'h5A;  8'h2D: c = 8'h58;  8'h2E: c = 8'h43;
      8'h2F: c = 8'h56;  8'h30: c = 8'h42;  8'h31: c = 8'h4E;  8'h32: c = 8'h4D;
      8'h33: c = 8'h3C;  8'h34: c = 8'h3E;  8'h35: c = 8'h3F;
      default: c = common_map(idx);
    endcase
    return c;
  endfunction

  // control map: letters minus 0x40, enter gives carriage return
  function automatic byte_t ctrl_map(input byte_t idx);
    byte_t c;
    unique case (idx)
      8'h10: c = 8'h11;  8'h11: c = 8'h17;  8'h12: c = 8'h05;  8'h13: c = 8'h12;
      8'h14: c = 8'h14;  8'h15: c = 8'h19;  8'h16: c = 8'h15;  8'h17: c = 8'h09;
      8'h18: c = 8'h0F;  8'h19: c = 8'h10;  8'h1C: c = 8'h0D;  8'h1E: c = 8'h01;
      8'h1F: c = 8'h13;  8'h20: c = 8'h04;  8'h21: c = 8'h06;  8'h22: c = 8'h07;
      8'h23: c = 8'h08;  8'h24: c = 8'h0A;  8'h25: c = 8'h0B;  8'h26: c = 8'h0C;
      8'h2B: c = 8'h1C;  8'h2C: c = 8'h1A;  8'h2D: c = 8'h18;  8'h2E: c = 8'h03;
      8'h2F: c = 8'h16;  8'h30: c = 8'h02;  8'h31: c = 8'h0E;  8'h32: c = 8'h0D;
      8'h35: c = 8'hEF;  8'h9C: c = 8'h0D;  8'hB5: c = 8'hEF;
      default: c = nav_map(idx);
    endcase
    return c;
  endfunction

endpackage

@@ rtl/scd_decode.sv @@
// next-state and character lookup for one scan code byte
// depends on scd_pkg
module scd_decode
  import scd_pkg::*;
(
  input  byte_t scan_byte_i,
  input  mod_t  mod_i,
  output byte_t char_code_o,
  output mod_t  mod_o
);

  // one step of the modifier register and the key maps
  always_comb begin
    byte_t idx;
    byte_t ch;
    mod_t  m;
    idx = scan_byte_i;
    ch  = 8'h00;
    m   = mod_i;
    if (scan_byte_i == CodePrefix) begin
      m[ModE0] = 1'b1;
    end else if (scan_byte_i[7]) begin
      // release: a plain release names the key without bit 7
      if (!mod_i[ModE0]) begin
        idx[7] = 1'b0;
      end
      m = m & ~hold_bits(idx);
      m[ModE0] = 1'b0;
    end else begin
      // press: prefixed keys live in the upper half of the maps
      if (mod_i[ModE0]) begin
        idx[7] = 1'b1;
        m[ModE0] = 1'b0;
      end
      m = (m | hold_bits(idx)) ^ lock_bits(idx);
      if (m[ModCtl]) begin
        ch = ctrl_map(idx);
      end else if (m[ModShift]) begin
        ch = upper_map(idx);
      end else begin
        ch = plain_map(idx);
      end
      // caps lock swaps letter case
      if (m[ModCaps]) begin
        if (ch >= 8'h61 && ch <= 8'h7A) begin
          ch = ch - 8'h20;
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
          ch = ch + 8'h20;
        end
      end
    end
    char_code_o = ch;
    mod_o       = m;
  end

endmodule

@@ rtl/scan_code_to_char_decoder.sv @@
// Set-1 scan code to character decoder, top level.
// Input channel: in_valid_i / in_ready_o with scan_byte_i, one raw byte a word.
// Output channel: out_valid_o / out_ready_i with char_code_o (0 when the
// byte gives no character) and modifier_flags_o (modifiers after that byte).
// Every input word yields exactly one output word, in order.
// From acceptance, the byte sits in an input register; the decode logic and the
// modifier register update then feed the output register.
// Throughput: one word a cycle while the receiver does not stall; the modifier
// register closes its loop through the decode logic.
// Reset clears both stage valids and the modifier register (all modifiers
// off, no prefix pending). When the receiver stalls, the output word holds,
// the input register keeps one more word, and in_ready_o drops only once
// both are full.
// depends on scd_pkg, scd_decode and scan_code_to_char_decoder_assert.svh
`include "scan_code_to_char_decoder_assert.svh"

module scan_code_to_char_decoder
  import scd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_code_o,
  output logic [6:0] modifier_flags_o
);

  logic  in_valid_q;
  byte_t in_byte_q;
  logic  out_valid_q;
  byte_t out_char_q;
  mod_t  out_mod_q;
  mod_t  mod_q;
  mod_t  mod_d;
  byte_t char_d;
  logic  out_free;
  logic  advance;

  // handshake between the two registers
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // decode the byte in the input register
  scd_decode u_decode (
    .scan_byte_i (in_byte_q),
    .mod_i       (mod_q),
    .char_code_o (char_d),
    .mod_o       (mod_d)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        mod_q <= mod_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= scan_byte_i;
    end
    if (advance) begin
      out_char_q <= char_d;
      out_mod_q  <= mod_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign char_code_o      = out_char_q;
  assign modifier_flags_o = out_mod_q;

  // a decoded prefix byte leaves the prefix flag pending
  `SCD_ASSERT_NEXT(a_prefix_sets_flag, advance && in_byte_q == CodePrefix, mod_q[ModE0])
  // a pending prefix in the output word means it came with no character
  `SCD_ASSERT_NOW(a_prefix_no_char, out_valid_q && out_mod_q[ModE0], out_char_q == 8'h00)
  // the shown flags are the live modifier register
  `SCD_ASSERT_NOW(a_flags_track_state, out_valid_q, out_mod_q == mod_q)

endmodule

@@ tb/scan_code_to_char_decoder_test.sv @@
// testbench for the set-1 scan code to character decoder
// directed table plus random key sequences, checked against the table or an own decode model
// depends on scd_pkg and the scan_code_to_char_decoder top level
`timescale 1ns / 1ps

module scan_code_to_char_decoder_test
  import scd_pkg::*;
();

  localparam int NumDirected = 26;
  localparam int NumRandom   = 1600;

  // letter rows and symbol rows of the key matrix, leftmost key in the top byte
  localparam logic [8*10-1:0] TopRow      = "qwertyuiop";
  localparam logic [8*9-1:0]  HomeRow     = "asdfghjkl";
  localparam logic [8*7-1:0]  BottomRow   = "zxcvbnm";
  localparam logic [8*12-1:0] DigitRow    = "1234567890-=";
  localparam logic [8*12-1:0] ShiftDigits = "!@#$%^&*()_+";
  localparam logic [8*13-1:0] KeypadRow   = "789-456+1230.";

  typedef struct packed {
    byte_t char_code;
    mod_t  mods;
  } decoded_t;

  typedef struct packed {
    byte_t code;
    logic  typed;
    byte_t char_code;
    mod_t  mods;
  } stim_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] char_code_o;
  logic [6:0] modifier_flags_o;

  decoded_t pending_words[$];
  mod_t     model_mods = '0;
  int       bad_words  = 0;
  int       words_sent = 0;
  int       burst_left = 0;

  // directed rows: typed expectations only where obvious
  stim_row_t directed_rows [NumDirected] = '{
    '{8'h00, 1'b1, 8'h00, 7'h00},  // lowest code right after reset
    '{8'h1E, 1'b1, 8'h61, 7'h00},  // plain 'a'
    '{8'h7F, 1'b1, 8'h00, 7'h00},  // highest press code, unmapped
    '{8'hFF, 1'b1, 8'h00, 7'h00},  // highest release code
    '{8'hE0, 1'b1, 8'h00, 7'h40},  // prefix arms the escape flag
    '{8'h47, 1'b1, 8'hE0, 7'h00},  // escaped home key
    '{8'h80, 1'b1, 8'h00, 7'h00},  // lowest release code
    '{8'h2A, 1'b1, 8'h00, 7'h01},  // left shift held
    '{8'h10, 1'b0, 8'h00, 7'h00},
    '{8'h35, 1'b0, 8'h00, 7'h00},
    '{8'hB6, 1'b1, 8'h00, 7'h00},  // right shift release clears the shift bit
    '{8'h1D, 1'b1, 8'h00, 7'h02},  // left control held
    '{8'h35, 1'b1, 8'hEF, 7'h02},  // control slash
    '{8'h2A, 1'b0, 8'h00, 7'h00},  // shift on top of control
    '{8'h1E, 1'b0, 8'h00, 7'h00},
    '{8'h9D, 1'b0, 8'h00, 7'h00},
    '{8'hAA, 1'b1, 8'h00, 7'h00},
    '{8'h3A, 1'b1, 8'h00, 7'h08},  // caps lock on
    '{8'h1E, 1'b0, 8'h00, 7'h00},
    '{8'hE0, 1'b0, 8'h00, 7'h00},
    '{8'h1D, 1'b0, 8'h00, 7'h00},  // right control
    '{8'hE0, 1'b0, 8'h00, 7'h00},
    '{8'h9D, 1'b0, 8'h00, 7'h00},  // escaped release of right control
    '{8'h45, 1'b0, 8'h00, 7'h00},
    '{8'hE0, 1'b0, 8'h00, 7'h00},
    '{8'h35, 1'b0, 8'h00, 7'h00}   // keypad slash
  };

  scan_code_to_char_decoder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .scan_byte_i      (scan_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .char_code_o      (char_code_o),
    .modifier_flags_o (modifier_flags_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hold modifiers named by a lookup index
  function automatic mod_t held_mask(input byte_t idx);
    mod_t k;
    k = '0;
    if (idx == CodeLCtl || idx == CodeRCtl) k[ModCtl] = 1'b1;
    if (idx == CodeLShift || idx == CodeRShift) k[ModShift] = 1'b1;
    if (idx == CodeLAlt || idx == CodeRAlt) k[ModAlt] = 1'b1;
    return k;
  endfunction

  // lock modifiers flipped by a press index
  function automatic mod_t lock_mask(input byte_t idx);
    mod_t k;
    k = '0;
    if (idx == CodeCaps) k[ModCaps] = 1'b1;
    if (idx == CodeNum) k[ModNum] = 1'b1;
    if (idx == CodeScroll) k[ModScroll] = 1'b1;
    return k;
  endfunction

  // character for a press index under the given modifiers, before caps
  function automatic byte_t key_char(input byte_t idx, input mod_t m);
    byte_t c;
    byte_t letter;
    int    ix;
    ix = int'(idx);
    c = 8'h00;
    letter = 8'h00;
    // navigation keys read the same in every map
    case (idx)
      8'hC7:   c = KeyHome;
      8'hC8:   c = KeyUp;
      8'hC9:   c = KeyPgUp;
      8'hCB:   c = KeyLeft;
      8'hCD:   c = KeyRt;
      8'hCF:   c = KeyEnd;
      8'hD0:   c = KeyDown;
      8'hD1:   c = KeyPgDn;
      8'hD2:   c = KeyIns;
      8'hD3:   c = KeyDel;
      default: c = 8'h00;
    endcase
    if (c != 8'h00) return c;
    // letters
    if (ix >= 'h10 && ix <= 'h19) letter = TopRow[8*('h19 - ix) +: 8];
    if (ix >= 'h1E && ix <= 'h26) letter = HomeRow[8*('h26 - ix) +: 8];
    if (ix >= 'h2C && ix <= 'h32) letter = BottomRow[8*('h32 - ix) +: 8];
    if (letter != 8'h00) begin
      if (m[ModCtl]) return letter - 8'h60;
      if (m[ModShift]) return letter - 8'h20;
      return letter;
    end
    // control map beyond letters
    if (m[ModCtl]) begin
      case (idx)
        8'h1C, 8'h9C: c = 8'h0D;
        8'h2B:        c = 8'h1C;
        8'h35, 8'hB5: c = 8'hEF;
        default:      c = 8'h00;
      endcase
      return c;
    end
    // plain and shifted maps
    if (ix >= 'h02 && ix <= 'h0D) begin
      if (m[ModShift]) return ShiftDigits[8*('h0D - ix) +: 8];
      return DigitRow[8*('h0D - ix) +: 8];
    end
    if (ix >= 'h47 && ix <= 'h53) return KeypadRow[8*('h53 - ix) +: 8];
    case (idx)
      8'h01:        c = 8'h1B;
      8'h0E:        c = 8'h08;
      8'h0F:        c = 8'h09;
      8'h1C, 8'h9C: c = 8'h0A;
      8'h37:        c = 8'h2A;
      8'h39:        c = 8'h20;
      8'hB5:        c = 8'h2F;
      8'h1A:        c = m[ModShift] ? 8'h7B : 8'h5B;
      8'h1B:        c = m[ModShift] ? 8'h7D : 8'h5D;
      8'h27:        c = m[ModShift] ? 8'h3A : 8'h3B;
      8'h28:        c = m[ModShift] ? 8'h22 : 8'h27;
      8'h29:        c = m[ModShift] ? 8'h7E : 8'h60;
      8'h2B:        c = m[ModShift] ? 8'h7C : 8'h5C;
      8'h33:        c = m[ModShift] ? 8'h3C : 8'h2C;
      8'h34:        c = m[ModShift] ? 8'h3E : 8'h2E;
      8'h35:        c = m[ModShift] ? 8'h3F : 8'h2F;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  // one decode step: new modifier state and the character
  function automatic decoded_t decode_scan_byte(input byte_t code, input mod_t m);
    decoded_t r;
    byte_t    idx;
    r.char_code = 8'h00;
    if (code == CodePrefix) begin
      m[ModE0] = 1'b1;
    end else if (code[7]) begin
      // release: escaped ones keep the full byte
      idx = m[ModE0] ? code : {1'b0, code[6:0]};
      m = m & ~held_mask(idx);
      m[ModE0] = 1'b0;
    end else begin
      idx = code;
      if (m[ModE0]) begin
        idx[7] = 1'b1;
        m[ModE0] = 1'b0;
      end
      m = m | held_mask(idx);
      m = m ^ lock_mask(idx);
      r.char_code = key_char(idx, m);
      // caps lock swaps letter case
      if (m[ModCaps]) begin
        if (r.char_code >= 8'h61 && r.char_code <= 8'h7A) r.char_code -= 8'h20;
        else if (r.char_code >= 8'h41 && r.char_code <= 8'h5A) r.char_code += 8'h20;
      end
    end
    r.mods = m;
    return r;
  endfunction

  // drive one word in bursts, predict it once accepted; entered and left at negedge
  task automatic send_word(input byte_t b, input logic typed, input decoded_t typed_word);
    int       gap;
    decoded_t d;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    d = decode_scan_byte(b, model_mods);
    model_mods = d.mods;
    pending_words.push_back(typed ? typed_word : d);
    words_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_key(input byte_t b);
    send_word(b, 1'b0, '0);
  endtask

  // hold off until every expected word has come back
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  function automatic byte_t any_key();
    return byte_t'($urandom_range(8'h01, 8'h58));
  endfunction

  // stimulus
  initial begin : stimulus
    int    pick;
    int    n;
    logic  pre;
    logic  paused;
    byte_t k;
    byte_t nav_codes [12];
    byte_t hold_codes [4];
    byte_t lock_codes [3];
    nav_codes  = '{8'h47, 8'h48, 8'h49, 8'h4B, 8'h4D, 8'h4F,
                   8'h50, 8'h51, 8'h52, 8'h53, 8'h1C, 8'h35};
    hold_codes = '{CodeLCtl, CodeLShift, CodeRShift, CodeLAlt};
    lock_codes = '{CodeCaps, CodeNum, CodeScroll};
    paused = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      send_word(directed_rows[i].code, directed_rows[i].typed,
                '{directed_rows[i].char_code, directed_rows[i].mods});
    end
    drain_words();

    // random key sequences
    words_sent = 0;
    while (words_sent < NumRandom) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // plain typing: press, mostly followed by release
        k = any_key();
        send_key(k);
        if ($urandom_range(0, 3) != 0) send_key(k | 8'h80);
      end else if (pick < 55) begin
        // chord with a hold modifier, control and alt sometimes escaped
        k = hold_codes[$urandom_range(0, 3)];
        pre = (k == CodeLCtl || k == CodeLAlt) && $urandom_range(0, 1);
        if (pre) send_key(CodePrefix);
        send_key(k);
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_key(any_key());
          if ($urandom_range(0, 1)) send_key(any_key() | 8'h80);
        end
        if ($urandom_range(0, 5) != 0) begin
          if (pre) send_key(CodePrefix);
          send_key(k | 8'h80);
        end
      end else if (pick < 65) begin
        // lock toggle
        k = lock_codes[$urandom_range(0, 2)];
        send_key(k);
        send_key(k | 8'h80);
      end else if (pick < 82) begin
        // escaped navigation and keypad keys
        k = nav_codes[$urandom_range(0, 11)];
        send_key(CodePrefix);
        send_key(k);
        if ($urandom_range(0, 3) != 0) begin
          send_key(CodePrefix);
          send_key(k | 8'h80);
        end
      end else begin
        // noise: any byte at all
        n = $urandom_range(1, 3);
        repeat (n) send_key(byte_t'($urandom_range(0, 255)));
      end
      if (!paused && words_sent >= NumRandom / 2) begin
        paused = 1'b1;
        drain_words();
      end
    end

    // wrap up
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("scan_code_to_char_decoder_test passed");
    end else begin
      $display("scan_code_to_char_decoder_test failed");
    end
    $finish;
  end

  // receiver ready pattern: segments of full speed, random and heavy stalls
  initial begin : receiver_stalls
    int mode;
    int seg;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(24, 160);
      repeat (seg) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin : check_output
    decoded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word: char_code %h, modifier_flags %h",
               char_code_o, modifier_flags_o);
        bad_words++;
      end else begin
        want = pending_words.pop_front();
        if (char_code_o !== want.char_code) begin
          $error("char_code: expected %h, actual %h", want.char_code, char_code_o);
          bad_words++;
        end
        if (modifier_flags_o !== want.mods) begin
          $error("modifier_flags: expected %h, actual %h", want.mods, modifier_flags_o);
          bad_words++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("scan_code_to_char_decoder_test failed");
    $finish;
  end

endmodule

@@ scan_code_to_char_decoder.f @@
+incdir+rtl
rtl/scd_pkg.sv
rtl/scd_decode.sv
rtl/scan_code_to_char_decoder.sv
tb/scan_code_to_char_decoder_test.sv
